@@ hw/rtl/timed_slot_ring_table_assert.svh @@
// ----------------------------------------------------------------------------
// Timed slot ring table assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_SLOT_RING_TABLE_ASSERT_SVH
`define TIMED_SLOT_RING_TABLE_ASSERT_SVH

// same-cycle implication
`define TSRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timed_slot_ring_table check failed");

// next-cycle implication
`define TSRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timed_slot_ring_table check failed");

`endif

@@ hw/rtl/tsrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Timed slot ring table package
// Shared constants, sequencer states and the lifetime table.
// ----------------------------------------------------------------------------
package tsrt_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned AGE_W     = 20;
  localparam int unsigned LIFE_W    = 19;
  localparam int unsigned MUL_W     = 32;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [15:0] UNIT_ONE = 16'd16384;
  localparam logic [14:0] SCALE_ONE = 15'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_EREAD,
    ST_SQX,
    ST_SQY,
    ST_LEN,
    ST_BA,
    ST_BB,
    ST_BC,
    ST_DONE
  } state_e;

  function automatic logic [LIFE_W-1:0] life_lut(input logic [7:0] ek, input logic [7:0] fam);
    logic [1:0] k;
    logic [1:0] f;
    logic [LIFE_W-1:0] v;
    k = (ek > 8'd3) ? 2'd1 : ek[1:0];
    f = (fam > 8'd2) ? 2'd0 : fam[1:0];
    case ({k, f})
      4'b0000: v = 19'd75000;
      4'b0001: v = 19'd60000;
      4'b0010: v = 19'd116250;
      4'b0100: v = 19'd280000;
      4'b0101: v = 19'd224000;
      4'b0110: v = 19'd434000;
      4'b1000: v = 19'd320000;
      4'b1001: v = 19'd256000;
      4'b1010: v = 19'd496000;
      4'b1100: v = 19'd140000;
      4'b1101: v = 19'd112000;
      4'b1110: v = 19'd217000;
      default: v = 19'd75000;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/timed_slot_ring_table.sv @@
// ----------------------------------------------------------------------------
// Timed slot ring table
// A tick makes one pass of reads over the slot memory, one slot per cycle.
// An emit finds each direction component bit by bit over 15 bits (a zero
// direction skips this), each bit passing through ST_BA, ST_BB and ST_BC on
// the one shared multiplier. After reset a clearing pass writes every slot
// before the first request is taken. busy_o is high from the accepting
// edge until the result strobe; the result is shown for one cycle only, and
// the receiver cannot stall it.
// ----------------------------------------------------------------------------
module timed_slot_ring_table #(
  parameter int unsigned SLOTS = tsrt_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               kind_i,
  input  logic [7:0]         effect_kind_i,
  input  logic [7:0]         family_code_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] scale_in_i,
  input  logic [19:0]        delta_us_i,
  output logic               result_valid_o,
  output logic [5:0]         slot_o,
  output logic               overwrote_live_o,
  output logic [18:0]        life_us_o,
  output logic signed [15:0] unit_x_o,
  output logic signed [15:0] unit_y_o,
  output logic [14:0]        scale_out_o,
  output logic [6:0]         live_count_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned IW = $clog2(SLOTS + 1);
  localparam int unsigned RW = 1 + tsrt_pkg::AGE_W + tsrt_pkg::LIFE_W;
  localparam int unsigned MW = tsrt_pkg::MUL_W;

  tsrt_pkg::state_e state_q, state_d;

  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] total_q, total_d;
  logic [AW-1:0] next_q, next_d;
  logic          p_q, p_d;
  logic [AW-1:0] paddr_q, paddr_d;
  logic          kind_q;
  logic [18:0]   life_q, life_d;
  logic signed [15:0] dx_q, dy_q;
  logic [14:0]   scale_q, scale_d;
  logic [19:0]   dt_q;
  logic [AW-1:0] slot_q, slot_d;
  logic          owl_q, owl_d;
  logic [31:0]   sqx_q, sqx_d, sqy_q, sqy_d, len2_q, len2_d;
  logic          comp_q, comp_d;
  logic [3:0]    bit_q, bit_d;
  logic [14:0]   n_q, n_d;
  logic signed [15:0] ux_q, ux_d, uy_q, uy_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [RW-1:0]   wdata, rdata;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;

  logic [15:0] magx, magy, tval;
  logic [14:0] cand;
  logic [20:0] age_sum;
  logic [19:0] age_sat;
  logic [31:0] c2;
  logic [15:0] rsig;

  tsrt_ram #(.Width(RW), .Depth(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tsrt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign magx = dx_q[15] ? 16'(~dx_q) + 16'd1 : 16'(dx_q);
  assign magy = dy_q[15] ? 16'(~dy_q) + 16'd1 : 16'(dy_q);
  assign cand = n_q | (15'd1 << bit_q);
  assign tval = {cand, 1'b0} - 16'd1;
  assign c2   = comp_q ? sqy_q : sqx_q;
  assign age_sum = {1'b0, rdata[RW-2 -: tsrt_pkg::AGE_W]} + {1'b0, dt_q};
  assign age_sat = age_sum[20] ? tsrt_pkg::AGE_MAX : age_sum[19:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsrt_pkg::ST_CLEAR;
      idx_q   <= '0;
      cnt_q   <= '0;
      total_q <= '0;
      next_q  <= '0;
      p_q     <= 1'b0;
      comp_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      next_q  <= next_d;
      p_q     <= p_d;
      comp_q  <= comp_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tsrt_pkg::ST_IDLE && start_i) begin
      kind_q <= kind_i;
      dx_q   <= dir_x_i;
      dy_q   <= dir_y_i;
      dt_q   <= delta_us_i;
    end
    paddr_q <= paddr_d;
    life_q  <= life_d;
    scale_q <= scale_d;
    slot_q  <= slot_d;
    owl_q   <= owl_d;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    len2_q  <= len2_d;
    n_q     <= n_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    next_d  = next_q;
    p_d     = 1'b0;
    paddr_d = paddr_q;
    life_d  = life_q;
    scale_d = scale_q;
    slot_d  = slot_q;
    owl_d   = owl_q;
    sqx_d   = sqx_q;
    sqy_d   = sqy_q;
    len2_d  = len2_q;
    comp_d  = comp_q;
    bit_d   = bit_q;
    n_d     = n_q;
    ux_d    = ux_q;
    uy_d    = uy_q;
    we      = 1'b0;
    waddr   = paddr_q;
    wdata   = '0;
    raddr   = next_q;
    mul_a   = '0;
    mul_b   = '0;
    rsig    = '0;

    case (state_q)
      tsrt_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        idx_d = idx_q + IW'(1);
        if (idx_q == IW'(SLOTS - 1)) begin
          idx_d   = '0;
          state_d = tsrt_pkg::ST_IDLE;
        end
      end
      tsrt_pkg::ST_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          cnt_d   = '0;
          life_d  = tsrt_pkg::life_lut(effect_kind_i, family_code_i);
          scale_d = (scale_in_i > 16'sd0) ? scale_in_i[14:0] : tsrt_pkg::SCALE_ONE;
          state_d = kind_i ? tsrt_pkg::ST_TICK : tsrt_pkg::ST_EREAD;
        end
      end
      tsrt_pkg::ST_TICK: begin
        raddr = idx_q[AW-1:0];
        if (idx_q != IW'(SLOTS)) begin
          p_d     = 1'b1;
          paddr_d = idx_q[AW-1:0];
          idx_d   = idx_q + IW'(1);
        end
        if (p_q && rdata[RW-1]) begin
          we    = 1'b1;
          waddr = paddr_q;
          if (age_sat >= {1'b0, rdata[tsrt_pkg::LIFE_W-1:0]}) begin
            wdata = {1'b0, age_sat, rdata[tsrt_pkg::LIFE_W-1:0]};
          end else begin
            wdata = {1'b1, age_sat, rdata[tsrt_pkg::LIFE_W-1:0]};
            cnt_d = cnt_q + IW'(1);
          end
        end
        if (idx_q == IW'(SLOTS)) begin
          total_d = cnt_d;
          state_d = tsrt_pkg::ST_DONE;
        end
      end
      tsrt_pkg::ST_EREAD: begin
        we     = 1'b1;
        waddr  = next_q;
        wdata  = {1'b1, {tsrt_pkg::AGE_W{1'b0}}, life_q};
        slot_d = next_q;
        owl_d  = rdata[RW-1];
        next_d = (next_q == AW'(SLOTS - 1)) ? '0 : next_q + AW'(1);
        if (!rdata[RW-1]) begin
          total_d = total_q + IW'(1);
        end
        state_d = tsrt_pkg::ST_SQX;
      end
      tsrt_pkg::ST_SQX: begin
        mul_a   = MW'(magx);
        mul_b   = MW'(magx);
        state_d = tsrt_pkg::ST_SQY;
      end
      tsrt_pkg::ST_SQY: begin
        mul_a   = MW'(magy);
        mul_b   = MW'(magy);
        sqx_d   = prod[31:0];
        state_d = tsrt_pkg::ST_LEN;
      end
      tsrt_pkg::ST_LEN: begin
        sqy_d  = prod[31:0];
        len2_d = sqx_q + prod[31:0];
        comp_d = 1'b0;
        bit_d  = 4'd14;
        n_d    = '0;
        if ((sqx_q | prod[31:0]) == 32'd0) begin
          ux_d    = '0;
          uy_d    = tsrt_pkg::UNIT_ONE;
          state_d = tsrt_pkg::ST_DONE;
        end else begin
          state_d = tsrt_pkg::ST_BA;
        end
      end
      tsrt_pkg::ST_BA: begin
        mul_a   = MW'(tval);
        mul_b   = MW'(tval);
        state_d = tsrt_pkg::ST_BB;
      end
      tsrt_pkg::ST_BB: begin
        mul_a   = prod[31:0];
        mul_b   = len2_q;
        state_d = tsrt_pkg::ST_BC;
      end
      tsrt_pkg::ST_BC: begin
        if (prod <= {2'b00, c2, 30'd0}) begin
          n_d = cand;
        end
        rsig = (comp_q ? dy_q[15] : dx_q[15]) ? 16'd0 - {1'b0, n_d} : {1'b0, n_d};
        if (bit_q == 4'd0) begin
          n_d    = '0;
          bit_d  = 4'd14;
          if (comp_q) begin
            uy_d    = rsig;
            state_d = tsrt_pkg::ST_DONE;
          end else begin
            ux_d    = rsig;
            comp_d  = 1'b1;
            state_d = tsrt_pkg::ST_BA;
          end
        end else begin
          bit_d   = bit_q - 4'd1;
          state_d = tsrt_pkg::ST_BA;
        end
      end
      tsrt_pkg::ST_DONE: begin
        state_d = tsrt_pkg::ST_IDLE;
      end
      default: begin
        state_d = tsrt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o           = (state_q != tsrt_pkg::ST_IDLE);
  assign result_valid_o   = (state_q == tsrt_pkg::ST_DONE);
  assign slot_o           = kind_q ? 6'd0 : 6'(slot_q);
  assign overwrote_live_o = kind_q ? 1'b0 : owl_q;
  assign life_us_o        = kind_q ? 19'd0 : life_q;
  assign unit_x_o         = kind_q ? 16'sd0 : ux_q;
  assign unit_y_o         = kind_q ? 16'sd0 : uy_q;
  assign scale_out_o      = kind_q ? 15'd0 : scale_q;
  assign live_count_o     = 7'(total_q);

endmodule

@@ hw/rtl/tsrt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/tsrt_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiply with a registered product.
// ----------------------------------------------------------------------------
module tsrt_mul (
  input  logic                         clk_i,
  input  logic [tsrt_pkg::MUL_W-1:0]   a_i,
  input  logic [tsrt_pkg::MUL_W-1:0]   b_i,
  output logic [2*tsrt_pkg::MUL_W-1:0] p_o
);

  logic [2*tsrt_pkg::MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/tsrt_checker.sv @@
// ----------------------------------------------------------------------------
// Timed slot ring table checker
// Port-level checks on request and result timing and on the unit vector range, bound to the top level.
// ----------------------------------------------------------------------------
`include "timed_slot_ring_table_assert.svh"

module tsrt_checker #(
  parameter int unsigned SLOTS = tsrt_pkg::SLOTS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               kind_i,
  input logic [7:0]         effect_kind_i,
  input logic [7:0]         family_code_i,
  input logic signed [15:0] dir_x_i,
  input logic signed [15:0] dir_y_i,
  input logic signed [15:0] scale_in_i,
  input logic [19:0]        delta_us_i,
  input logic               result_valid_o,
  input logic [5:0]         slot_o,
  input logic               overwrote_live_o,
  input logic [18:0]        life_us_o,
  input logic signed [15:0] unit_x_o,
  input logic signed [15:0] unit_y_o,
  input logic [14:0]        scale_out_o,
  input logic [6:0]         live_count_o
);

  `TSRT_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !result_valid_o)
  `TSRT_ASSERT_NOW(a_result_busy, result_valid_o, busy_o)
  `TSRT_ASSERT_NEXT(a_result_single, result_valid_o, !result_valid_o && !busy_o)
  `TSRT_ASSERT_NOW(a_unit_range, result_valid_o,
                   unit_x_o >= -16'sd16384 && unit_x_o <= 16'sd16384 &&
                   unit_y_o >= -16'sd16384 && unit_y_o <= 16'sd16384)

endmodule

bind timed_slot_ring_table tsrt_checker #(.SLOTS(SLOTS)) u_tsrt_checker (.*);

@@ bench/tb_timed_slot_ring_table.sv @@
// ----------------------------------------------------------------------------
// Timed slot ring table testbench
// Drives emit and tick requests through the start/busy handshake, predicts
// each result from a behavioural model of the slot ring, and checks every
// strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_timed_slot_ring_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 64;
  localparam int unsigned AGE_TOP = 1048575;
  localparam logic KIND_EMIT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ek;
    logic [7:0]  fam;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] sc;
    logic [19:0] dt;
  } req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        ovw;
    logic [18:0] life;
    logic [15:0] ux;
    logic [15:0] uy;
    logic [14:0] scale;
    logic [6:0]  cnt;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic kind_i = 1'b0;
  logic [7:0] effect_kind_i = '0;
  logic [7:0] family_code_i = '0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] scale_in_i = '0;
  logic [19:0] delta_us_i = '0;
  logic busy_o, result_valid_o, overwrote_live_o;
  logic [5:0] slot_o;
  logic [18:0] life_us_o;
  logic signed [15:0] unit_x_o, unit_y_o;
  logic [14:0] scale_out_o;
  logic [6:0] live_count_o;

  timed_slot_ring_table u_dut (.*);

  always #6 clk_i = ~clk_i;

  req_t pending_q[$];
  res_t expected_q[$];
  int   errors = 0;
  int   idle_pct = 0;
  bit   fed_all = 0;

  bit          ring_live[NSLOT];
  int unsigned ring_age[NSLOT];
  int unsigned ring_life[NSLOT];
  int unsigned ring_next = 0;
  int unsigned ring_total = 0;

  function automatic int unsigned life_of(logic [7:0] ek, logic [7:0] fam);
    int unsigned tbl[4][3] = '{'{75000, 60000, 116250}, '{280000, 224000, 434000},
                              '{320000, 256000, 496000}, '{140000, 112000, 217000}};
    int k, f;
    k = (ek > 3) ? 1 : int'(ek);
    f = (fam > 2) ? 0 : int'(fam);
    return tbl[k][f];
  endfunction

  function automatic logic [15:0] norm_comp(int c, longint unsigned len2);
    longint unsigned m, rhs, t;
    int lo, hi, mid;
    m = (c < 0) ? -c : c;
    rhs = (m * m) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic res_t ring_apply(req_t r);
    res_t o;
    int unsigned cnt, a, s;
    int dx, dy, sc;
    longint unsigned len2;
    o = '0;
    if (r.kind == KIND_TICK) begin
      cnt = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (ring_live[i]) begin
          a = ring_age[i] + r.dt;
          if (a > AGE_TOP) a = AGE_TOP;
          ring_age[i] = a;
          if (a >= ring_life[i]) ring_live[i] = 0;
          else cnt++;
        end
      end
      ring_total = cnt;
    end else begin
      s = ring_next;
      dx = $signed(r.dx);
      dy = $signed(r.dy);
      sc = $signed(r.sc);
      o.ovw = ring_live[s];
      if (!ring_live[s]) ring_total++;
      ring_next = (s + 1) % NSLOT;
      ring_live[s] = 1;
      ring_age[s] = 0;
      ring_life[s] = life_of(r.ek, r.fam);
      len2 = longint'(dx * dx) + longint'(dy * dy);
      if (len2 == 0) begin
        o.ux = 16'd0;
        o.uy = 16'd16384;
      end else begin
        o.ux = norm_comp(dx, len2);
        o.uy = norm_comp(dy, len2);
      end
      o.slot = s[5:0];
      o.life = ring_life[s][18:0];
      o.scale = (sc > 0) ? sc[14:0] : 15'd256;
    end
    o.cnt = ring_total[6:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    req_t r;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        r = pending_q.pop_front();
        expected_q.push_back(ring_apply(r));
      end
      if ((!start_i || !busy_o) && pending_q.size() > 0
          && $urandom_range(99) >= idle_pct) begin
        r = pending_q[0];
        start_i <= 1'b1;
        kind_i <= r.kind;
        effect_kind_i <= r.ek;
        family_code_i <= r.fam;
        dir_x_i <= r.dx;
        dir_y_i <= r.dy;
        scale_in_i <= r.sc;
        delta_us_i <= r.dt;
      end else if (start_i && !busy_o) begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && result_valid_o) begin
      got = '{slot_o, overwrote_live_o, life_us_o, unit_x_o, unit_y_o, scale_out_o,
              live_count_o};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.slot != exp_r.slot) begin
          $display("%0t slot exp %0d got %0d", $realtime, exp_r.slot, got.slot); errors++;
        end
        if (got.ovw != exp_r.ovw) begin
          $display("%0t overwrote exp %0d got %0d", $realtime, exp_r.ovw, got.ovw); errors++;
        end
        if (got.life != exp_r.life) begin
          $display("%0t life exp %0d got %0d", $realtime, exp_r.life, got.life); errors++;
        end
        if (got.ux != exp_r.ux) begin
          $display("%0t unit_x exp %0d got %0d", $realtime, $signed(exp_r.ux),
                   $signed(got.ux)); errors++;
        end
        if (got.uy != exp_r.uy) begin
          $display("%0t unit_y exp %0d got %0d", $realtime, $signed(exp_r.uy),
                   $signed(got.uy)); errors++;
        end
        if (got.scale != exp_r.scale) begin
          $display("%0t scale exp %0d got %0d", $realtime, exp_r.scale, got.scale); errors++;
        end
        if (got.cnt != exp_r.cnt) begin
          $display("%0t live_count exp %0d got %0d", $realtime, exp_r.cnt, got.cnt); errors++;
        end
      end
    end
  end

  function automatic req_t emit_req(logic [7:0] ek, logic [7:0] fam, logic [15:0] dx,
                                    logic [15:0] dy, logic [15:0] sc);
    req_t r;
    r = '{KIND_EMIT, ek, fam, dx, dy, sc, 20'($urandom)};
    return r;
  endfunction

  function automatic req_t tick_req(logic [19:0] dt);
    req_t r;
    r = '{KIND_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), dt};
    return r;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  function automatic req_t rand_req();
    int p;
    p = $urandom_range(99);
    if (p < 25) begin
      case ($urandom_range(3))
        0: return tick_req(20'($urandom_range(150000)));
        1: return tick_req(20'($urandom_range(20000)));
        2: return tick_req(20'($urandom));
        default: return tick_req(20'd0);
      endcase
    end
    return emit_req($urandom_range(9) ? 8'($urandom_range(3)) : 8'($urandom),
                    $urandom_range(9) ? 8'($urandom_range(2)) : 8'($urandom),
                    rand_dir(), ($urandom_range(15) == 0) ? 16'd0 : rand_dir(),
                    16'($urandom));
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;
    for (int k = 0; k < 4; k++)
      for (int f = 0; f < 3; f++)
        pending_q.push_back(emit_req(8'(k), 8'(f), 16'($urandom), 16'($urandom), 16'(f)));
    pending_q.push_back(emit_req(8'd255, 8'd255, 16'd0, 16'd0, 16'h8000));
    pending_q.push_back(emit_req(8'd4, 8'd3, 16'h8000, 16'h8000, 16'h7fff));
    pending_q.push_back(emit_req(8'd0, 8'd0, 16'h7fff, 16'h0000, 16'hffff));
    pending_q.push_back(emit_req(8'd1, 8'd1, 16'h0001, 16'hffff, 16'd1));
    pending_q.push_back(emit_req(8'd2, 8'd2, 16'h0003, 16'h0004, 16'd256));
    pending_q.push_back(tick_req(20'd0));
    pending_q.push_back(tick_req(20'd60000));
    pending_q.push_back(tick_req(20'd15000));
    pending_q.push_back(tick_req(20'hfffff));
    pending_q.push_back(tick_req(20'hfffff));
    for (int i = 0; i < 70; i++) pending_q.push_back(emit_req(8'd2, 8'd2, 16'd1, 16'd1, 16'd0));
    pending_q.push_back(tick_req(20'd495999));
    pending_q.push_back(tick_req(20'd1));
    for (int i = 0; i < 1650; i++) begin
      if (i == 550) begin
        drain();
        idle_pct = 64;
      end
      if (i == 1100) begin
        drain();
        idle_pct = 0;
      end
      pending_q.push_back(rand_req());
      if (pending_q.size() > 8) @(posedge clk_i);
    end
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
